### rtl/triangle_unit_normal_defines.svh
// Assertion macros used by the checker file of the triangle normal unit
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define TUN_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define TUN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tun_pkg.sv
// Shared types and constants of the triangle unit normal block
package tun_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int CROSS_WIDTH = 2 * DIFF_WIDTH + 1;
   localparam int OUT_WIDTH   = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ax;
      logic signed [COORD_WIDTH-1:0] ay;
      logic signed [COORD_WIDTH-1:0] az;
      logic signed [COORD_WIDTH-1:0] bx;
      logic signed [COORD_WIDTH-1:0] by_coord;
      logic signed [COORD_WIDTH-1:0] bz;
      logic signed [COORD_WIDTH-1:0] cx;
      logic signed [COORD_WIDTH-1:0] cy;
      logic signed [COORD_WIDTH-1:0] cz;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] nx;
      logic signed [OUT_WIDTH-1:0] ny;
      logic signed [OUT_WIDTH-1:0] nz;
      logic                        degenerate;
   } rsp_type;

   typedef struct packed {
      logic signed [CROSS_WIDTH-1:0] wx;
      logic signed [CROSS_WIDTH-1:0] wy;
      logic signed [CROSS_WIDTH-1:0] wz;
      logic                          degenerate;
   } cross_type;

endpackage

### rtl/tun_queue.sv
// Short queue of cross products between the front and back pipelines
module tun_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_push,
   input  tun_pkg::cross_type  wr_data,
   output logic                wr_full,
   input  logic                rd_pop,
   output tun_pkg::cross_type  rd_data,
   output logic                rd_empty
);
   import tun_pkg::*;

   cross_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0] rptr_ff, rptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_wr, do_rd;

   assign wr_full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign rd_empty = (count_ff == '0);
   assign do_wr    = wr_push && !wr_full;
   assign do_rd    = rd_pop && !rd_empty;
   assign rd_data  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rptr_ff + 1'b1;
      end
      case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/tun_front.sv
// Front pipeline: edge vectors, cross product and degenerate detection
module tun_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tun_pkg::req_type    req_data,
   output logic                full,
   output logic                cross_valid,
   output tun_pkg::cross_type  cross_data,
   input  logic                cross_ready
);
   import tun_pkg::*;

   localparam int PROD_W = 2 * DIFF_WIDTH;

   logic [2:0]                    vld_ff, vld_in;
   logic                          adv;
   logic signed [DIFF_WIDTH-1:0]  u_ff [3];
   logic signed [DIFF_WIDTH-1:0]  v_ff [3];
   logic signed [DIFF_WIDTH-1:0]  u_in [3];
   logic signed [DIFF_WIDTH-1:0]  v_in [3];
   logic signed [PROD_W-1:0]      pa_ff [3];
   logic signed [PROD_W-1:0]      pb_ff [3];
   logic signed [PROD_W-1:0]      pa_in [3];
   logic signed [PROD_W-1:0]      pb_in [3];
   cross_type                     cr_ff, cr_in;

   // hold everything while the last stage waits on a full queue
   assign adv         = !(vld_ff[2] && !cross_ready);
   assign full        = !adv;
   assign vld_in      = {vld_ff[1:0], push && adv};
   assign cross_valid = vld_ff[2];
   assign cross_data  = cr_ff;

   always_comb begin
      u_in[0] = {req_data.bx[COORD_WIDTH-1], req_data.bx}
              - {req_data.ax[COORD_WIDTH-1], req_data.ax};
      u_in[1] = {req_data.by_coord[COORD_WIDTH-1], req_data.by_coord}
              - {req_data.ay[COORD_WIDTH-1], req_data.ay};
      u_in[2] = {req_data.bz[COORD_WIDTH-1], req_data.bz}
              - {req_data.az[COORD_WIDTH-1], req_data.az};
      v_in[0] = {req_data.cx[COORD_WIDTH-1], req_data.cx}
              - {req_data.ax[COORD_WIDTH-1], req_data.ax};
      v_in[1] = {req_data.cy[COORD_WIDTH-1], req_data.cy}
              - {req_data.ay[COORD_WIDTH-1], req_data.ay};
      v_in[2] = {req_data.cz[COORD_WIDTH-1], req_data.cz}
              - {req_data.az[COORD_WIDTH-1], req_data.az};
   end

   always_comb begin
      pa_in[0] = u_ff[1] * v_ff[2];
      pb_in[0] = u_ff[2] * v_ff[1];
      pa_in[1] = u_ff[2] * v_ff[0];
      pb_in[1] = u_ff[0] * v_ff[2];
      pa_in[2] = u_ff[0] * v_ff[1];
      pb_in[2] = u_ff[1] * v_ff[0];
   end

   always_comb begin
      cr_in.wx = {pa_ff[0][PROD_W-1], pa_ff[0]} - {pb_ff[0][PROD_W-1], pb_ff[0]};
      cr_in.wy = {pa_ff[1][PROD_W-1], pa_ff[1]} - {pb_ff[1][PROD_W-1], pb_ff[1]};
      cr_in.wz = {pa_ff[2][PROD_W-1], pa_ff[2]} - {pb_ff[2][PROD_W-1], pb_ff[2]};
      cr_in.degenerate = (pa_ff[0] == pb_ff[0]) && (pa_ff[1] == pb_ff[1])
                      && (pa_ff[2] == pb_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff  <= u_in;
         v_ff  <= v_in;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         cr_ff <= cr_in;
      end
   end

endmodule

### rtl/tun_back.sv
// Back pipeline: squared length and bit-per-stage normalization
module tun_back #(
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cross_valid,
   input  tun_pkg::cross_type  cross_data,
   output logic                cross_pop,
   output logic                rsp_valid,
   output tun_pkg::rsp_type    rsp_data,
   input  logic                rsp_ready
);
   import tun_pkg::*;

   localparam int FRAC    = NORMAL_FRAC_BITS;
   localparam int MAG_W   = CROSS_WIDTH - 1;
   localparam int HALF_LO = (MAG_W + 1) / 2;
   localparam int HALF_HI = MAG_W - HALF_LO;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int DW      = SQ_W + 2 * FRAC + 8;
   localparam int NSTG    = FRAC + 6;
   localparam int OUT_IDX = NSTG - 1;

   typedef struct packed {
      logic                 neg;
      logic signed [DW-1:0] d;
      logic signed [DW-1:0] p;
      logic [FRAC:0]        q;
   } comp_type;

   typedef struct packed {
      logic [SUM_W-1:0] s;
      comp_type [2:0]   c;
   } srch_type;

   logic                           adv;
   logic [NSTG-1:0]                vld_ff, vld_in;
   logic [NSTG-1:0]                deg_ff, deg_in;
   logic signed [CROSS_WIDTH-1:0]  w [3];
   logic [2:0]                     negp_ff, negp_in, negq_ff, negs_ff;
   logic [2*HALF_LO-1:0]           ll_ff [3];
   logic [2*HALF_LO-1:0]           ll_in [3];
   logic [MAG_W-1:0]               lh_ff [3];
   logic [MAG_W-1:0]               lh_in [3];
   logic [2*HALF_HI-1:0]           hh_ff [3];
   logic [2*HALF_HI-1:0]           hh_in [3];
   logic [SQ_W-1:0]                sq_ff [3];
   logic [SQ_W-1:0]                sq_in [3];
   logic [SQ_W-1:0]                sq2_ff [3];
   logic [SUM_W-1:0]               s_ff, s_in;
   srch_type                       srch_ff [FRAC+2];
   srch_type                       init_in;
   rsp_type                        out_ff, out_in;

   // the whole pipeline moves together; stall only on a waiting result
   assign adv       = !(vld_ff[OUT_IDX] && !rsp_ready);
   assign cross_pop = adv && cross_valid;
   assign vld_in    = {vld_ff[NSTG-2:0], cross_valid};
   assign deg_in    = {deg_ff[NSTG-2:0], cross_data.degenerate};
   assign rsp_valid = vld_ff[OUT_IDX];
   assign rsp_data  = out_ff;

   assign w[0] = cross_data.wx;
   assign w[1] = cross_data.wy;
   assign w[2] = cross_data.wz;

   // magnitude split in halves so each square is three narrow products
   always_comb begin
      logic [CROSS_WIDTH-1:0] abs_w;
      logic [HALF_LO-1:0]     al;
      logic [HALF_HI-1:0]     ah;
      for (int i = 0; i < 3; i++) begin
         negp_in[i] = w[i][CROSS_WIDTH-1];
         abs_w      = w[i][CROSS_WIDTH-1] ? -w[i] : w[i];
         al         = abs_w[HALF_LO-1:0];
         ah         = abs_w[MAG_W-1:HALF_LO];
         ll_in[i]   = al * al;
         lh_in[i]   = al * ah;
         hh_in[i]   = ah * ah;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (SQ_W'(hh_ff[i]) << (2 * HALF_LO))
                  + (SQ_W'(lh_ff[i]) << (HALF_LO + 1))
                  + SQ_W'(ll_ff[i]);
      end
   end

   assign s_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);

   // start each search at q = 0: d = 4*w^2*2^(2F) - s, p = s*(2q-1)
   always_comb begin
      init_in.s = s_ff;
      for (int i = 0; i < 3; i++) begin
         init_in.c[i].neg = negs_ff[i];
         init_in.c[i].d   = (DW'(sq2_ff[i]) << (2 * FRAC + 2)) - DW'(s_ff);
         init_in.c[i].p   = -DW'(s_ff);
         init_in.c[i].q   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         deg_ff     <= deg_in;
         negp_ff    <= negp_in;
         ll_ff      <= ll_in;
         lh_ff      <= lh_in;
         hh_ff      <= hh_in;
         negq_ff    <= negp_ff;
         sq_ff      <= sq_in;
         negs_ff    <= negq_ff;
         sq2_ff     <= sq_ff;
         s_ff       <= s_in;
         srch_ff[0] <= init_in;
         out_ff     <= out_in;
      end
   end

   // one result bit per stage, from the top bit down
   for (genvar j = 0; j <= FRAC; j++) begin : g_srch
      localparam int K = FRAC - j;
      srch_type srch_in;

      always_comb begin
         logic signed [DW-1:0] s_w;
         logic signed [DW-1:0] trial;
         srch_in = srch_ff[j];
         s_w     = DW'(srch_ff[j].s);
         for (int i = 0; i < 3; i++) begin
            trial = srch_ff[j].c[i].d - (srch_ff[j].c[i].p << (K + 2))
                  - (s_w << (2 * K + 2));
            if (!trial[DW-1]) begin
               srch_in.c[i].d    = trial;
               srch_in.c[i].p    = srch_ff[j].c[i].p + (s_w << (K + 1));
               srch_in.c[i].q[K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            srch_ff[j+1] <= srch_in;
         end
      end
   end

   // apply sign, mask to the field, zero out a degenerate triangle
   always_comb begin
      logic [FRAC+OUT_WIDTH+1:0] val [3];
      for (int i = 0; i < 3; i++) begin
         val[i] = {{(OUT_WIDTH+1){1'b0}}, srch_ff[FRAC+1].c[i].q};
         if (srch_ff[FRAC+1].c[i].neg) begin
            val[i] = -val[i];
         end
         if (deg_ff[NSTG-2]) begin
            val[i] = '0;
         end
      end
      out_in.nx         = val[0][OUT_WIDTH-1:0];
      out_in.ny         = val[1][OUT_WIDTH-1:0];
      out_in.nz         = val[2][OUT_WIDTH-1:0];
      out_in.degenerate = deg_ff[NSTG-2];
   end

endmodule

### rtl/triangle_unit_normal.sv
// Triangle unit normal: top level joining front pipeline, queue and back pipeline
//
// Takes one triangle (three vertices, signed coordinates with 12 fraction
// bits) per transaction on the req side and returns one transaction on the
// rsp side holding the unit normal of the cross product (B-A) x (C-A), each
// component rounded to nearest with ties away from zero, in signed fixed
// point with NORMAL_FRAC_BITS fraction bits masked to 16 bits. A triangle
// whose cross product is zero returns a zero normal with degenerate set.
// Results leave in the order triangles arrive. Throughput is one triangle
// per clock while the rsp side pops every result. A triangle passes the
// front pipeline (edge vectors, products, cross product), the queue, and
// the back pipeline: products of the magnitude halves, squares, sum of
// squares, search setup, then one pipeline stage per result bit
// (NORMAL_FRAC_BITS + 1 stages), then the output register. The queue
// lets a new triangle enter while a result waits to be popped; a stall on
// the rsp side first holds the back pipeline, and the front keeps filling
// the queue until it is full.
module triangle_unit_normal #(
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  tun_pkg::req_type  req_data,
   output logic              empty,
   input  logic              pop,
   output tun_pkg::rsp_type  rsp_data
);
   import tun_pkg::*;

   logic       fr_valid;
   cross_type  fr_data;
   logic       q_full;
   logic       q_empty;
   cross_type  q_data;
   logic       bk_pop;
   logic       bk_valid;

   // cross product for each accepted transaction
   tun_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_data    (req_data),
      .full        (full),
      .cross_valid (fr_valid),
      .cross_data  (fr_data),
      .cross_ready (!q_full)
   );

   // decouple the stall of the two pipelines
   tun_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (fr_valid),
      .wr_data  (fr_data),
      .wr_full  (q_full),
      .rd_pop   (bk_pop),
      .rd_data  (q_data),
      .rd_empty (q_empty)
   );

   // normalize and present the result
   tun_back #(
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cross_valid (!q_empty),
      .cross_data  (q_data),
      .cross_pop   (bk_pop),
      .rsp_valid   (bk_valid),
      .rsp_data    (rsp_data),
      .rsp_ready   (pop)
   );

   assign empty = !bk_valid;

endmodule

### rtl/tun_checker.sv
// Port-level checker for the triangle unit normal, bound to the top level
`include "triangle_unit_normal_defines.svh"

module tun_checker (
   input logic              clock,
   input logic              reset,
   input logic              full,
   input logic              empty,
   input logic              pop,
   input tun_pkg::rsp_type  rsp_data
);
   import tun_pkg::*;

   logic rsp_stall;
   logic deg_shown;
   logic zero_normal;

   assign rsp_stall   = !empty && !pop;
   assign deg_shown   = !empty && rsp_data.degenerate;
   assign zero_normal = (rsp_data.nx == '0) && (rsp_data.ny == '0) && (rsp_data.nz == '0);

   `TUN_ASSERT_IMP(a_deg_zero, deg_shown, zero_normal, "degenerate result with nonzero normal")
   `TUN_ASSERT_IMP(a_reset_idle, $past(reset), empty && !full, "not idle after reset")
   `TUN_ASSERT_NEXT(a_hold_valid, rsp_stall, !empty, "stalled result dropped")
   `TUN_ASSERT_NEXT(a_hold_data, rsp_stall, $stable(rsp_data), "stalled result changed")

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (.*);

### bench/tb.sv
// Self-checking testbench for the triangle unit normal block
`timescale 1ns / 100ps

module tb;
   import tun_pkg::*;

   localparam int FRAC_BITS   = 14;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RAND_ITEMS  = 400;
   localparam int DRAIN_WAIT  = 60;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   logic    full;
   logic    empty;
   req_type req_data = '0;
   rsp_type rsp_data;

   // Triangles waiting to be offered, and normals still owed by the block
   req_type triangle_queue[$];
   rsp_type normal_queue[$];

   int unsigned error_count = 0;
   int unsigned accepted_count = 0;
   int unsigned checked_count = 0;
   int unsigned degenerate_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned holdoff_left = 0;
   int unsigned pop_phase = 0;
   bit          holdoff_done = 1'b0;

   triangle_unit_normal #(.NORMAL_FRAC_BITS(FRAC_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #1 clock = ~clock;

   // Round one cross-product component over the vector length: the largest
   // q in [0, 2^F] with (2q-1)^2 * s <= 4 * w^2 * 2^(2F), then apply the sign.
   function automatic logic [15:0] round_component(logic signed [63:0] w, logic [159:0] s);
      logic [63:0]  mag;
      logic [159:0] bound;
      logic [159:0] lhs;
      logic [159:0] odd;
      logic [31:0]  lo;
      logic [31:0]  hi;
      logic [31:0]  mid;
      mag = (w < 0) ? -w : w;
      bound = (160'(mag) * 160'(mag)) << (2 * FRAC_BITS + 2);
      lo = 0;
      hi = 32'd1 << FRAC_BITS;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         odd = 160'(2 * mid - 1);
         lhs = odd * odd * s;
         if (lhs <= bound) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return (w < 0) ? 16'(-lo) : 16'(lo);
   endfunction

   // Unit normal of (B - A) x (C - A), zero with the degenerate flag when the
   // cross product vanishes.
   function automatic rsp_type unit_normal(req_type t);
      logic signed [63:0] u1, u2, u3, v1, v2, v3;
      logic signed [63:0] w1, w2, w3;
      logic [159:0]       len_sq;
      rsp_type            n;
      u1 = 64'(t.bx) - 64'(t.ax);
      u2 = 64'(t.by_coord) - 64'(t.ay);
      u3 = 64'(t.bz) - 64'(t.az);
      v1 = 64'(t.cx) - 64'(t.ax);
      v2 = 64'(t.cy) - 64'(t.ay);
      v3 = 64'(t.cz) - 64'(t.az);
      w1 = u2 * v3 - u3 * v2;
      w2 = u3 * v1 - u1 * v3;
      w3 = u1 * v2 - u2 * v1;
      len_sq = 160'(160'(w1) * 160'(w1)) + 160'(160'(w2) * 160'(w2))
             + 160'(160'(w3) * 160'(w3));
      n = '0;
      if (len_sq == 0) begin
         n.degenerate = 1'b1;
      end else begin
         n.nx = round_component(w1, len_sq);
         n.ny = round_component(w2, len_sq);
         n.nz = round_component(w3, len_sq);
      end
      return n;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on normal %0d: %s got %0d expected %0d",
               checked_count, what, got, want);
      error_count++;
   endtask

   function automatic req_type make_triangle(
      int ax, int ay, int az, int bx, int by, int bz, int cx, int cy, int cz);
      req_type t;
      t.ax = 24'(ax); t.ay = 24'(ay); t.az = 24'(az);
      t.bx = 24'(bx); t.by_coord = 24'(by); t.bz = 24'(bz);
      t.cx = 24'(cx); t.cy = 24'(cy); t.cz = 24'(cz);
      return t;
   endfunction

   function automatic logic [23:0] any_coord();
      case ($urandom_range(0, 3))
         0:       return 24'($urandom_range(0, 8191)) - 24'd4096;
         1:       return 24'($urandom_range(0, 255)) << 12;
         default: return 24'($urandom);
      endcase
   endfunction

   // Driver: send triangles in bursts separated by random gaps. Keep push
   // high across back-to-back transactions so it is assigned once per edge.
   always @(posedge clock) begin
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (push && !full) begin
            // This transaction is taken now; predict its normal.
            normal_queue.push_back(unit_normal(triangle_queue.pop_front()));
            accepted_count <= accepted_count + 1;
         end
         if (!(push && full)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               push <= 1'b0;
            end else if (triangle_queue.size() > 0) begin
               push <= 1'b1;
               req_data <= triangle_queue[0];
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 20);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off once the run is under way, so the queue fills
   // and full backs up onto the sender.
   always @(posedge clock) begin
      if (!holdoff_done && accepted_count == 60) begin
         holdoff_done <= 1'b1;
         holdoff_left <= 120;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // Monitor: check every popped transaction against the oldest prediction,
   // then pick the next pop: low during the hold-off, else from a stall
   // pattern that alternates between always-ready and random stretches.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (pop && !empty) begin
            if (normal_queue.size() == 0) begin
               report_mismatch("unexpected normal, none owed", 0, 0);
            end else begin
               want = normal_queue.pop_front();
               if (rsp_data.nx !== want.nx)
                  report_mismatch("nx", int'(rsp_data.nx), int'(want.nx));
               if (rsp_data.ny !== want.ny)
                  report_mismatch("ny", int'(rsp_data.ny), int'(want.ny));
               if (rsp_data.nz !== want.nz)
                  report_mismatch("nz", int'(rsp_data.nz), int'(want.nz));
               if (rsp_data.degenerate !== want.degenerate)
                  report_mismatch("degenerate", int'(rsp_data.degenerate),
                                  int'(want.degenerate));
               if (want.degenerate)
                  degenerate_count <= degenerate_count + 1;
            end
            checked_count <= checked_count + 1;
         end
         pop_phase <= pop_phase + 1;
         if (holdoff_left > 0)
            pop <= 1'b0;
         else if (pop_phase[6])
            pop <= ($urandom_range(0, 2) != 0);
         else
            pop <= 1'b1;
      end
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d normals outstanding",
                  cycle_count, normal_queue.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int     i;
      int     k;
      req_type t;

      // Directed: coincident and collinear vertices, axis-aligned faces in
      // every orientation, and coordinate extremes.
      triangle_queue.push_back(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
      triangle_queue.push_back(make_triangle(5, 6, 7, 5, 6, 7, 5, 6, 7));
      triangle_queue.push_back(make_triangle(0, 0, 0, 4096, 4096, 4096, 8192, 8192, 8192));
      triangle_queue.push_back(make_triangle(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
      triangle_queue.push_back(make_triangle(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
      triangle_queue.push_back(make_triangle(0, 0, 0, 0, 4096, 0, 0, 0, 4096));
      triangle_queue.push_back(make_triangle(0, 0, 0, 0, 0, 4096, 0, 4096, 0));
      triangle_queue.push_back(make_triangle(0, 0, 0, 0, 0, 4096, 4096, 0, 0));
      triangle_queue.push_back(make_triangle(0, 0, 0, 4096, 0, 0, 0, 0, 4096));
      triangle_queue.push_back(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
      triangle_queue.push_back(make_triangle(0, 0, 0, 1, 1, 0, 0, 1, 1));
      triangle_queue.push_back(make_triangle(0, 0, 0, 3, 0, 0, 0, 4, 5));
      triangle_queue.push_back(make_triangle(-8388608, -8388608, -8388608,
                                             8388607, -8388608, -8388608,
                                             -8388608, 8388607, -8388608));
      triangle_queue.push_back(make_triangle(8388607, 8388607, 8388607,
                                             -8388608, 8388607, 8388607,
                                             8388607, -8388608, 8388607));
      triangle_queue.push_back(make_triangle(-8388608, 8388607, -8388608,
                                             8388607, -8388608, 8388607,
                                             -8388608, -8388608, 8388607));
      triangle_queue.push_back(make_triangle(-8388608, -8388608, -8388608,
                                             8388607, 8388607, 8388607,
                                             -8388608, -8388608, -8388608));
      triangle_queue.push_back(make_triangle(-1, -1, -1, 0, 0, 0, 1, 2, 3));
      triangle_queue.push_back(make_triangle(100, -200, 300, -400, 500, -600,
                                             700, 800, -900));

      // Random: mostly general triangles, some collinear ones.
      for (i = 0; i < RAND_ITEMS; i++) begin
         t.ax = any_coord(); t.ay = any_coord(); t.az = any_coord();
         t.bx = any_coord(); t.by_coord = any_coord(); t.bz = any_coord();
         if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(0, 4) - 2;
            t.cx = 24'(t.ax + k * (t.bx - t.ax));
            t.cy = 24'(t.ay + k * (t.by_coord - t.ay));
            t.cz = 24'(t.az + k * (t.bz - t.az));
         end else begin
            t.cx = any_coord(); t.cy = any_coord(); t.cz = any_coord();
         end
         triangle_queue.push_back(t);
      end

      // Hold reset, then release it.
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Drain: all sent, all owed normals returned, then a final wait before the report.
      wait (triangle_queue.size() == 0 && !push && normal_queue.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d triangles and checked %0d normals, %0d of them degenerate,",
               accepted_count, checked_count, degenerate_count);
      $display("with bursty input, random output stalls and one long output hold-off.");
      if (error_count == 0 && normal_queue.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/tun_pkg.sv
rtl/tun_queue.sv
rtl/tun_front.sv
rtl/tun_back.sv
rtl/triangle_unit_normal.sv
rtl/tun_checker.sv
bench/tb.sv
